// File: hw/rtl/tmpg_pkg.sv
// Package with the shared types, constants and helper functions of the torus point generator.
`timescale 1ns / 1ps
`default_nettype none
package tmpg_pkg;

    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int STEP_W   = 16;
    localparam int RADIUS_W = 16;
    localparam int COORD_W  = 18;
    localparam int VERTEX_W = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CORDIC_W = 20;
    localparam int ANGLE_W  = 16;
    localparam int CORDIC_ITERS = 16;

    localparam int DEF_MAX_RINGS    = 1024;
    localparam int DEF_MAX_SEGMENTS = 1024;
    localparam int DEF_PHASE_BITS   = 16;

    localparam logic [COUNT_W-1:0]  RST_RING_COUNT    = 11'd16;
    localparam logic [COUNT_W-1:0]  RST_SEGMENT_COUNT = 11'd16;
    localparam logic [STEP_W-1:0]   RST_RING_STEP     = 16'd4096;
    localparam logic [STEP_W-1:0]   RST_SEGMENT_STEP  = 16'd4096;
    localparam logic [RADIUS_W-1:0] RST_MAJOR_RADIUS  = 16'd4096;
    localparam logic [RADIUS_W-1:0] RST_MINOR_RADIUS  = 16'd819;

    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 20'sd39797;
    localparam int COORD_MAX = 131071;
    localparam int COORD_MIN = -131072;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RING_COUNT    = 3'd0,
        REG_SEGMENT_COUNT = 3'd1,
        REG_RING_STEP     = 3'd2,
        REG_SEGMENT_STEP  = 3'd3,
        REG_MAJOR_RADIUS  = 3'd4,
        REG_MINOR_RADIUS  = 3'd5
    } tmpg_reg_t;

    localparam logic signed [ANGLE_W-1:0] ARC_TABLE [CORDIC_ITERS] = '{
        16'sd8192, 16'sd4836, 16'sd2555, 16'sd1297, 16'sd651, 16'sd326, 16'sd163, 16'sd81,
        16'sd41, 16'sd20, 16'sd10, 16'sd5, 16'sd3, 16'sd1, 16'sd1, 16'sd0
    };

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [ANGLE_W-1:0]  z;
    } tmpg_cordic_t;

    typedef struct packed {
        logic                bad;
        logic [VERTEX_W-1:0] row_base;
        logic [VERTEX_W-1:0] row_next;
        logic [INDEX_W-1:0]  seg;
        logic [COUNT_W-1:0]  seg_next;
        logic [1:0]          quad_t;
        logic [1:0]          quad_p;
    } tmpg_side_t;

    function automatic tmpg_cordic_t cordic_iter(input tmpg_cordic_t a, input int k);
        tmpg_cordic_t r;
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        dx = a.y >>> k;
        dy = a.x >>> k;
        if (!a.z[ANGLE_W-1])
        begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - ARC_TABLE[k];
        end
        else
        begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + ARC_TABLE[k];
        end
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [27:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > 28'sd131071)
            r = 18'sd131071;
        else if (v < -28'sd131072)
            r = -18'sd131072;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tmpg_point_if.sv
// Request channel that carries one grid point.
`timescale 1ns / 1ps
`default_nettype none
interface tmpg_point_if;
    logic       valid;
    logic       ready;
    logic [9:0] ring_index;
    logic [9:0] segment_index;

    modport source (output valid, output ring_index, output segment_index, input ready);
    modport sink (input valid, input ring_index, input segment_index, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tmpg_vertex_if.sv
// Request channel that carries one vertex with its cell indices.
`timescale 1ns / 1ps
`default_nettype none
interface tmpg_vertex_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic signed [17:0] pos_z;
    logic [19:0]        base_vertex;
    logic [19:0]        right_vertex;
    logic [19:0]        diagonal_vertex;
    logic [19:0]        down_vertex;
    logic               bad_index;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output base_vertex, output right_vertex, output diagonal_vertex,
                    output down_vertex, output bad_index, input ready);
    modport sink (input valid, input pos_x, input pos_y, input pos_z,
                  input base_vertex, input right_vertex, input diagonal_vertex,
                  input down_vertex, input bad_index, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tmpg_cfg_if.sv
// Configuration write channel with register index and write data.
`timescale 1ns / 1ps
`default_nettype none
interface tmpg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/torus_mesh_point_generator_unit.sv
// Top level of the torus mesh point generator: a fourteen stage vertex pipeline.
// Throughput is one grid point per cycle while the output is not stalled; the two CORDIC
// rotators, two iterations per stage over eight stages, set the pipeline depth.
// A stall at the output holds every stage; nothing is lost or repeated.
// Reset clears all valid bits and loads the configuration registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none
module torus_mesh_point_generator_unit #(
    parameter int MAX_RINGS    = tmpg_pkg::DEF_MAX_RINGS,
    parameter int MAX_SEGMENTS = tmpg_pkg::DEF_MAX_SEGMENTS,
    parameter int PHASE_BITS   = tmpg_pkg::DEF_PHASE_BITS
) (
    input wire logic       clk,
    input wire logic       rst_n,
    tmpg_point_if.sink     point,
    tmpg_vertex_if.source  vertex,
    tmpg_cfg_if.sink       cfg
);
    import tmpg_pkg::*;

    localparam int PROD_W = INDEX_W + STEP_W;
    localparam int CSTAGES = CORDIC_ITERS / 2;
    localparam int NV = CSTAGES + 6;

    logic [COUNT_W-1:0]  ring_count_reg;
    logic [COUNT_W-1:0]  segment_count_reg;
    logic [STEP_W-1:0]   ring_step_reg;
    logic [STEP_W-1:0]   segment_step_reg;
    logic [RADIUS_W-1:0] major_radius_reg;
    logic [RADIUS_W-1:0] minor_radius_reg;

    logic [NV-1:0] vld_reg;
    logic [NV-1:0] vld_next;
    logic          advance;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_count_reg    <= RST_RING_COUNT;
            segment_count_reg <= RST_SEGMENT_COUNT;
            ring_step_reg     <= RST_RING_STEP;
            segment_step_reg  <= RST_SEGMENT_STEP;
            major_radius_reg  <= RST_MAJOR_RADIUS;
            minor_radius_reg  <= RST_MINOR_RADIUS;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_RING_COUNT:    ring_count_reg    <= cfg.data[COUNT_W-1:0];
                REG_SEGMENT_COUNT: segment_count_reg <= cfg.data[COUNT_W-1:0];
                REG_RING_STEP:     ring_step_reg     <= cfg.data;
                REG_SEGMENT_STEP:  segment_step_reg  <= cfg.data;
                REG_MAJOR_RADIUS:  major_radius_reg  <= cfg.data;
                REG_MINOR_RADIUS:  minor_radius_reg  <= cfg.data;
                default:           ;
            endcase
        end
    end

    // The whole pipeline moves together whenever the output register can take a result.
    assign advance     = !vld_reg[NV-1] || vertex.ready;
    assign point.ready = advance;
    assign vld_next    = {vld_reg[NV-2:0], point.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= vld_next;
    end

    // Stage 1: effective counts, range check and wrapped neighbors.
    logic [COUNT_W-1:0] ring_eff;
    logic [COUNT_W-1:0] seg_eff;
    logic [INDEX_W-1:0] ri_reg;
    logic [INDEX_W-1:0] si_reg;
    logic               bad1_reg;
    logic [COUNT_W-1:0] ri1_reg;
    logic [COUNT_W-1:0] si1_reg;
    logic               bad1_next;
    logic [COUNT_W-1:0] ri1_next;
    logic [COUNT_W-1:0] si1_next;
    logic [COUNT_W-1:0] ri_inc;
    logic [COUNT_W-1:0] si_inc;

    always_comb
    begin
        if (ring_count_reg == '0)
            ring_eff = COUNT_W'(1);
        else if (32'(ring_count_reg) > MAX_RINGS)
            ring_eff = COUNT_W'(MAX_RINGS);
        else
            ring_eff = ring_count_reg;
        if (segment_count_reg == '0)
            seg_eff = COUNT_W'(1);
        else if (32'(segment_count_reg) > MAX_SEGMENTS)
            seg_eff = COUNT_W'(MAX_SEGMENTS);
        else
            seg_eff = segment_count_reg;
        ri_inc    = COUNT_W'(point.ring_index) + COUNT_W'(1);
        si_inc    = COUNT_W'(point.segment_index) + COUNT_W'(1);
        ri1_next  = (ri_inc == ring_eff) ? '0 : ri_inc;
        si1_next  = (si_inc == seg_eff) ? '0 : si_inc;
        bad1_next = (COUNT_W'(point.ring_index) >= ring_eff)
                 || (COUNT_W'(point.segment_index) >= seg_eff);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ri_reg   <= point.ring_index;
            si_reg   <= point.segment_index;
            bad1_reg <= bad1_next;
            ri1_reg  <= ri1_next;
            si1_reg  <= si1_next;
        end
    end

    // Stage 2: phases and row offsets.
    logic [PROD_W-1:0]       prod_t;
    logic [PROD_W-1:0]       prod_p;
    logic [ANGLE_W-1:0]      ph_t;
    logic [ANGLE_W-1:0]      ph_p;
    logic [2*COUNT_W-1:0]    row_base_full;
    logic [2*COUNT_W-1:0]    row_next_full;
    tmpg_side_t              side2_next;
    tmpg_side_t              side2_reg;
    tmpg_cordic_t            rot_t2_next;
    tmpg_cordic_t            rot_p2_next;
    tmpg_cordic_t            rot_t2_reg;
    tmpg_cordic_t            rot_p2_reg;

    assign prod_t = PROD_W'(ri_reg) * PROD_W'(ring_step_reg);
    assign prod_p = PROD_W'(si_reg) * PROD_W'(segment_step_reg);

    if (PHASE_BITS >= ANGLE_W)
    begin : g_phase_down
        assign ph_t = prod_t[PHASE_BITS-1 -: ANGLE_W];
        assign ph_p = prod_p[PHASE_BITS-1 -: ANGLE_W];
    end
    else
    begin : g_phase_up
        assign ph_t = {prod_t[PHASE_BITS-1:0], {(ANGLE_W-PHASE_BITS){1'b0}}};
        assign ph_p = {prod_p[PHASE_BITS-1:0], {(ANGLE_W-PHASE_BITS){1'b0}}};
    end

    always_comb
    begin
        row_base_full       = (2*COUNT_W)'(ri_reg) * (2*COUNT_W)'(seg_eff);
        row_next_full       = (2*COUNT_W)'(ri1_reg) * (2*COUNT_W)'(seg_eff);
        side2_next.bad      = bad1_reg;
        side2_next.row_base = row_base_full[VERTEX_W-1:0];
        side2_next.row_next = row_next_full[VERTEX_W-1:0];
        side2_next.seg      = si_reg;
        side2_next.seg_next = si1_reg;
        side2_next.quad_t   = ph_t[ANGLE_W-1 -: 2];
        side2_next.quad_p   = ph_p[ANGLE_W-1 -: 2];
        rot_t2_next.x       = CORDIC_START;
        rot_t2_next.y       = '0;
        rot_t2_next.z       = {2'b00, ph_t[ANGLE_W-3:0]};
        rot_p2_next.x       = CORDIC_START;
        rot_p2_next.y       = '0;
        rot_p2_next.z       = {2'b00, ph_p[ANGLE_W-3:0]};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side2_reg  <= side2_next;
            rot_t2_reg <= rot_t2_next;
            rot_p2_reg <= rot_p2_next;
        end
    end

    // CORDIC stages: two iterations each, both angles side by side.
    tmpg_cordic_t rot_t_reg [CSTAGES];
    tmpg_cordic_t rot_p_reg [CSTAGES];
    tmpg_side_t   side_c_reg [CSTAGES];

    for (genvar s = 0; s < CSTAGES; s++)
    begin : g_cordic
        tmpg_cordic_t in_t;
        tmpg_cordic_t in_p;
        tmpg_side_t   in_side;
        tmpg_cordic_t rot_t_next;
        tmpg_cordic_t rot_p_next;

        if (s == 0)
        begin : g_first
            assign in_t    = rot_t2_reg;
            assign in_p    = rot_p2_reg;
            assign in_side = side2_reg;
        end
        else
        begin : g_rest
            assign in_t    = rot_t_reg[s-1];
            assign in_p    = rot_p_reg[s-1];
            assign in_side = side_c_reg[s-1];
        end

        assign rot_t_next = cordic_iter(cordic_iter(in_t, 2*s), 2*s+1);
        assign rot_p_next = cordic_iter(cordic_iter(in_p, 2*s), 2*s+1);

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rot_t_reg[s]  <= rot_t_next;
                rot_p_reg[s]  <= rot_p_next;
                side_c_reg[s] <= in_side;
            end
        end
    end

    // Stage 3: quadrant mapping and vertex indices.
    tmpg_cordic_t               fin_t;
    tmpg_cordic_t               fin_p;
    tmpg_side_t                 side_f;
    logic signed [CORDIC_W-1:0] ct_next;
    logic signed [CORDIC_W-1:0] st_next;
    logic signed [CORDIC_W-1:0] cp_next;
    logic signed [CORDIC_W-1:0] sp_next;
    logic signed [CORDIC_W-1:0] ct_reg;
    logic signed [CORDIC_W-1:0] st_reg;
    logic signed [CORDIC_W-1:0] cp3_reg;
    logic signed [CORDIC_W-1:0] sp3_reg;
    logic [VERTEX_W-1:0]        base3_reg;
    logic [VERTEX_W-1:0]        right3_reg;
    logic [VERTEX_W-1:0]        diag3_reg;
    logic [VERTEX_W-1:0]        down3_reg;
    logic                       bad3_reg;

    assign fin_t  = rot_t_reg[CSTAGES-1];
    assign fin_p  = rot_p_reg[CSTAGES-1];
    assign side_f = side_c_reg[CSTAGES-1];

    always_comb
    begin
        unique case (side_f.quad_t)
            2'd0:    begin ct_next = fin_t.x;  st_next = fin_t.y;  end
            2'd1:    begin ct_next = -fin_t.y; st_next = fin_t.x;  end
            2'd2:    begin ct_next = -fin_t.x; st_next = -fin_t.y; end
            default: begin ct_next = fin_t.y;  st_next = -fin_t.x; end
        endcase
        unique case (side_f.quad_p)
            2'd0:    begin cp_next = fin_p.x;  sp_next = fin_p.y;  end
            2'd1:    begin cp_next = -fin_p.y; sp_next = fin_p.x;  end
            2'd2:    begin cp_next = -fin_p.x; sp_next = -fin_p.y; end
            default: begin cp_next = fin_p.y;  sp_next = -fin_p.x; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ct_reg     <= ct_next;
            st_reg     <= st_next;
            cp3_reg    <= cp_next;
            sp3_reg    <= sp_next;
            base3_reg  <= side_f.row_base + VERTEX_W'(side_f.seg);
            right3_reg <= side_f.row_base + VERTEX_W'(side_f.seg_next);
            diag3_reg  <= side_f.row_next + VERTEX_W'(side_f.seg_next);
            down3_reg  <= side_f.row_next + VERTEX_W'(side_f.seg);
            bad3_reg   <= side_f.bad;
        end
    end

    // Stage 4: ring radius and z product.
    logic signed [36:0]         rct;
    logic signed [36:0]         zprod_next;
    logic signed [35:0]         t_next;
    logic signed [35:0]         t_reg;
    logic signed [36:0]         zprod_reg;
    logic signed [CORDIC_W-1:0] cp4_reg;
    logic signed [CORDIC_W-1:0] sp4_reg;
    logic [VERTEX_W-1:0]        base4_reg;
    logic [VERTEX_W-1:0]        right4_reg;
    logic [VERTEX_W-1:0]        diag4_reg;
    logic [VERTEX_W-1:0]        down4_reg;
    logic                       bad4_reg;

    assign rct        = $signed({1'b0, minor_radius_reg}) * ct_reg;
    assign zprod_next = $signed({1'b0, minor_radius_reg}) * st_reg;
    assign t_next     = $signed({4'd0, major_radius_reg, 16'd0}) + 36'(rct);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            t_reg      <= t_next;
            zprod_reg  <= zprod_next;
            cp4_reg    <= cp3_reg;
            sp4_reg    <= sp3_reg;
            base4_reg  <= base3_reg;
            right4_reg <= right3_reg;
            diag4_reg  <= diag3_reg;
            down4_reg  <= down3_reg;
            bad4_reg   <= bad3_reg;
        end
    end

    // Stage 5: split products for x and y, rounded and saturated z.
    logic signed [38:0]        phx_next;
    logic signed [37:0]        plx_next;
    logic signed [38:0]        phy_next;
    logic signed [37:0]        ply_next;
    logic signed [37:0]        zr;
    logic signed [38:0]        phx_reg;
    logic signed [37:0]        plx_reg;
    logic signed [38:0]        phy_reg;
    logic signed [37:0]        ply_reg;
    logic signed [COORD_W-1:0] z5_reg;
    logic [VERTEX_W-1:0]       base5_reg;
    logic [VERTEX_W-1:0]       right5_reg;
    logic [VERTEX_W-1:0]       diag5_reg;
    logic [VERTEX_W-1:0]       down5_reg;
    logic                      bad5_reg;

    assign phx_next = $signed(t_reg[35:17]) * cp4_reg;
    assign plx_next = $signed({1'b0, t_reg[16:0]}) * cp4_reg;
    assign phy_next = $signed(t_reg[35:17]) * sp4_reg;
    assign ply_next = $signed({1'b0, t_reg[16:0]}) * sp4_reg;
    assign zr       = 38'(zprod_reg) + 38'sd32768;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            phx_reg    <= phx_next;
            plx_reg    <= plx_next;
            phy_reg    <= phy_next;
            ply_reg    <= ply_next;
            z5_reg     <= sat_coord(28'($signed(zr[37:16])));
            base5_reg  <= base4_reg;
            right5_reg <= right4_reg;
            diag5_reg  <= diag4_reg;
            down5_reg  <= down4_reg;
            bad5_reg   <= bad4_reg;
        end
    end

    // Stage 6: sums, rounding, saturation, zeroing of out-of-grid results and the output register.
    logic signed [56:0]        sx;
    logic signed [56:0]        sy;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [COORD_W-1:0] z_reg;
    logic [VERTEX_W-1:0]       base_reg;
    logic [VERTEX_W-1:0]       right_reg;
    logic [VERTEX_W-1:0]       diag_reg;
    logic [VERTEX_W-1:0]       down_reg;
    logic                      bad_reg;

    assign sx = (57'(phx_reg) <<< 17) + 57'(plx_reg) + (57'sd1 <<< 31);
    assign sy = (57'(phy_reg) <<< 17) + 57'(ply_reg) + (57'sd1 <<< 31);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bad_reg <= bad5_reg;
            if (bad5_reg)
            begin
                x_reg     <= '0;
                y_reg     <= '0;
                z_reg     <= '0;
                base_reg  <= '0;
                right_reg <= '0;
                diag_reg  <= '0;
                down_reg  <= '0;
            end
            else
            begin
                x_reg     <= sat_coord(28'($signed(sx[56:32])));
                y_reg     <= sat_coord(28'($signed(sy[56:32])));
                z_reg     <= z5_reg;
                base_reg  <= base5_reg;
                right_reg <= right5_reg;
                diag_reg  <= diag5_reg;
                down_reg  <= down5_reg;
            end
        end
    end

    assign vertex.valid           = vld_reg[NV-1];
    assign vertex.pos_x           = x_reg;
    assign vertex.pos_y           = y_reg;
    assign vertex.pos_z           = z_reg;
    assign vertex.base_vertex     = base_reg;
    assign vertex.right_vertex    = right_reg;
    assign vertex.diagonal_vertex = diag_reg;
    assign vertex.down_vertex     = down_reg;
    assign vertex.bad_index       = bad_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (point.valid && point.ready) |=> vld_reg[0])
        else $error("Accepted request did not enter the first stage.");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vertex.valid && !vertex.ready) |=> $stable(vld_reg))
        else $error("Pipeline valid bits moved during an output stall.");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vertex.valid && vertex.bad_index) |-> (vertex.pos_x == '0 && vertex.pos_y == '0
        && vertex.pos_z == '0 && vertex.base_vertex == '0 && vertex.down_vertex == '0))
        else $error("Out-of-grid result carries nonzero fields.");

endmodule
`default_nettype wire

// File: bench/torus_mesh_point_generator_unit_tb.sv
// Testbench for the torus mesh point generator: directed and random grid points checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module torus_mesh_point_generator_unit_tb;
    import tmpg_pkg::*;

    typedef struct packed {
        logic [9:0] ring;
        logic [9:0] seg;
    } grid_point_t;

    typedef struct packed {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic [19:0]        base;
        logic [19:0]        right;
        logic [19:0]        diag;
        logic [19:0]        down;
        logic               bad;
    } vertex_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors = 0;
    int   recv_count = 0;
    int   sent_count = 0;
    int   gap_left = 0;
    int   stall_left = 0;

    logic [10:0] ring_count_q;
    logic [10:0] segment_count_q;
    logic [15:0] ring_step_q;
    logic [15:0] segment_step_q;
    logic [15:0] major_radius_q;
    logic [15:0] minor_radius_q;

    grid_point_t pending_points[$];
    vertex_t     expected_vertices[$];

    tmpg_point_if  point();
    tmpg_vertex_if vertex();
    tmpg_cfg_if    cfg();

    torus_mesh_point_generator_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point),
        .vertex (vertex),
        .cfg    (cfg)
    );

    always #4 clk = ~clk;

    function automatic longint floor_sr(longint v, int k);
        return v >>> k;
    endfunction

    function automatic void rotate_phase(input logic [9:0] idx, input logic [15:0] step,
                                         output longint c, output longint s);
        logic [15:0] p;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        p = 16'(longint'(idx) * longint'(step));
        x = 39797;
        y = 0;
        z = p[13:0];
        for (int k = 0; k < 16; k++)
        begin
            dx = floor_sr(y, k);
            dy = floor_sr(x, k);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ARC_TABLE[k];
            end
            else
            begin
                x += dx; y -= dy; z += ARC_TABLE[k];
            end
        end
        case (p[15:14])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic signed [17:0] clamp_coord(longint v);
        if (v > 131071)
            return 18'sd131071;
        if (v < -131072)
            return -18'sd131072;
        return 18'(v);
    endfunction

    function automatic vertex_t torus_vertex(grid_point_t pt);
        vertex_t r;
        longint  m;
        longint  n;
        longint  i;
        longint  j;
        longint  i1;
        longint  j1;
        longint  ct;
        longint  st;
        longint  cp;
        longint  sp;
        longint  t;
        r = '0;
        m = (ring_count_q == 0) ? 1 : (ring_count_q > 1024) ? 1024 : ring_count_q;
        n = (segment_count_q == 0) ? 1 : (segment_count_q > 1024) ? 1024 : segment_count_q;
        i = pt.ring;
        j = pt.seg;
        if (i >= m || j >= n)
        begin
            r.bad = 1'b1;
            return r;
        end
        rotate_phase(pt.ring, ring_step_q, ct, st);
        rotate_phase(pt.seg, segment_step_q, cp, sp);
        t = (longint'(major_radius_q) << 16) + longint'(minor_radius_q) * ct;
        r.x = clamp_coord(floor_sr(t * cp + (64'sd1 << 31), 32));
        r.y = clamp_coord(floor_sr(t * sp + (64'sd1 << 31), 32));
        r.z = clamp_coord(floor_sr(longint'(minor_radius_q) * st + (64'sd1 << 15), 16));
        i1 = (i + 1 == m) ? 0 : i + 1;
        j1 = (j + 1 == n) ? 0 : j + 1;
        r.base = 20'(i * n + j);
        r.right = 20'(i * n + j1);
        r.diag = 20'(i1 * n + j1);
        r.down = 20'(i1 * n + j);
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 40)
            return 0;
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point.valid <= 1'b0;
            point.ring_index <= '0;
            point.segment_index <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (point.valid && point.ready)
            begin
                expected_vertices.push_back(torus_vertex({point.ring_index,
                                                          point.segment_index}));
                sent_count <= sent_count + 1;
            end
            if (!point.valid || point.ready)
            begin
                if (gap_left > 0)
                begin
                    point.valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (pending_points.size() > 0)
                begin
                    grid_point_t nxt;
                    nxt = pending_points.pop_front();
                    point.valid <= 1'b1;
                    point.ring_index <= nxt.ring;
                    point.segment_index <= nxt.seg;
                    gap_left <= pick_gap();
                end
                else
                    point.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (vertex.valid && vertex.ready)
            begin
                vertex_t got;
                vertex_t want;
                got = {vertex.pos_x, vertex.pos_y, vertex.pos_z, vertex.base_vertex,
                       vertex.right_vertex, vertex.diagonal_vertex, vertex.down_vertex,
                       vertex.bad_index};
                recv_count <= recv_count + 1;
                if (expected_vertices.size() == 0)
                begin
                    $error("unexpected vertex request");
                    errors++;
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    if (got.x !== want.x)
                        begin $error("pos_x exp %0d got %0d", want.x, got.x); errors++; end
                    if (got.y !== want.y)
                        begin $error("pos_y exp %0d got %0d", want.y, got.y); errors++; end
                    if (got.z !== want.z)
                        begin $error("pos_z exp %0d got %0d", want.z, got.z); errors++; end
                    if (got.base !== want.base)
                        begin $error("base_vertex exp %0d got %0d", want.base, got.base);
                        errors++; end
                    if (got.right !== want.right)
                        begin $error("right_vertex exp %0d got %0d", want.right, got.right);
                        errors++; end
                    if (got.diag !== want.diag)
                        begin $error("diagonal_vertex exp %0d got %0d", want.diag, got.diag);
                        errors++; end
                    if (got.down !== want.down)
                        begin $error("down_vertex exp %0d got %0d", want.down, got.down);
                        errors++; end
                    if (got.bad !== want.bad)
                        begin $error("bad_index exp %0d got %0d", want.bad, got.bad);
                        errors++; end
                end
            end
            if (stall_left > 0)
            begin
                vertex.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
            begin
                vertex.ready <= 1'b1;
                stall_left <= ($urandom_range(0, 99) < 25) ? pick_gap() : 0;
            end
        end
    end

    task automatic write_reg(tmpg_reg_t idx, logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            REG_RING_COUNT:    ring_count_q = value[10:0];
            REG_SEGMENT_COUNT: segment_count_q = value[10:0];
            REG_RING_STEP:     ring_step_q = value;
            REG_SEGMENT_STEP:  segment_step_q = value;
            REG_MAJOR_RADIUS:  major_radius_q = value;
            default:           minor_radius_q = value;
        endcase
        @(posedge clk);
    endtask

    task automatic run_points(int count, int edge_pct);
        int target;
        target = sent_count + pending_points.size() + count;
        for (int k = 0; k < count; k++)
        begin
            grid_point_t pt;
            int m;
            int n;
            m = (ring_count_q == 0) ? 1 : (ring_count_q > 1024) ? 1024 : ring_count_q;
            n = (segment_count_q == 0) ? 1 : (segment_count_q > 1024) ? 1024 : segment_count_q;
            if ($urandom_range(0, 99) < edge_pct)
            begin
                pt.ring = 10'($urandom_range(0, 1023));
                pt.seg = 10'($urandom_range(0, 1023));
            end
            else
            begin
                pt.ring = ($urandom_range(0, 3) == 0) ? 10'(m - 1) : 10'($urandom_range(0, m - 1));
                pt.seg = ($urandom_range(0, 3) == 0) ? 10'(n - 1) : 10'($urandom_range(0, n - 1));
            end
            pending_points.push_back(pt);
        end
        wait (sent_count == target && expected_vertices.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        ring_count_q = RST_RING_COUNT;
        segment_count_q = RST_SEGMENT_COUNT;
        ring_step_q = RST_RING_STEP;
        segment_step_q = RST_SEGMENT_STEP;
        major_radius_q = RST_MAJOR_RADIUS;
        minor_radius_q = RST_MINOR_RADIUS;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        pending_points.push_back({10'd0, 10'd0});
        pending_points.push_back({10'd15, 10'd15});
        pending_points.push_back({10'd15, 10'd0});
        pending_points.push_back({10'd0, 10'd15});
        pending_points.push_back({10'd16, 10'd3});
        pending_points.push_back({10'd3, 10'd16});
        pending_points.push_back({10'd1023, 10'd1023});
        pending_points.push_back({10'd4, 10'd8});
        run_points(0, 0);

        write_reg(REG_RING_COUNT, 16'd1024);
        write_reg(REG_SEGMENT_COUNT, 16'd1024);
        write_reg(REG_RING_STEP, 16'd64);
        write_reg(REG_SEGMENT_STEP, 16'd64);
        write_reg(REG_MAJOR_RADIUS, 16'hFFFF);
        write_reg(REG_MINOR_RADIUS, 16'hFFFF);
        pending_points.push_back({10'd1023, 10'd1023});
        pending_points.push_back({10'd512, 10'd256});
        pending_points.push_back({10'd0, 10'd768});
        run_points(60, 10);

        write_reg(REG_RING_COUNT, 16'd0);
        write_reg(REG_SEGMENT_COUNT, 16'd0);
        write_reg(REG_MAJOR_RADIUS, 16'd0);
        write_reg(REG_MINOR_RADIUS, 16'd0);
        run_points(20, 50);

        write_reg(REG_RING_COUNT, 16'd2047);
        write_reg(REG_SEGMENT_COUNT, 16'd1025);
        write_reg(REG_RING_STEP, 16'hFFFF);
        write_reg(REG_SEGMENT_STEP, 16'd0);
        write_reg(REG_MINOR_RADIUS, 16'd40000);
        run_points(60, 10);

        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(REG_RING_COUNT, 16'($urandom_range(1, 40)));
            write_reg(REG_SEGMENT_COUNT, 16'($urandom_range(1, 1024)));
            write_reg(REG_RING_STEP, 16'($urandom_range(0, 65535)));
            write_reg(REG_SEGMENT_STEP, 16'($urandom_range(0, 65535)));
            write_reg(REG_MAJOR_RADIUS, 16'($urandom_range(0, 65535)));
            write_reg(REG_MINOR_RADIUS, 16'($urandom_range(0, 65535)));
            run_points(50, 15);
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
